FILE: rtl/metropolis_ion_move_step_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ion move step block
// Concurrent checks that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef METROPOLIS_ION_MOVE_STEP_MACROS_SVH
`define METROPOLIS_ION_MOVE_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define MIMS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MIMS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MIMS_ASSERT_IMP(label, ante, cons, msg)
`define MIMS_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/mims_pkg.sv
// ---------------------------------------------------------------------------
// Ion move step package
// Shared types, codes and the exponential table.
// ---------------------------------------------------------------------------
`default_nettype none
package mims_pkg;

    localparam int STORE_W = 49;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_MOVE = 1'b1;

    localparam logic [1:0] STATUS_LOADED   = 2'd0;
    localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
    localparam logic [1:0] STATUS_REJECTED = 2'd2;

    localparam logic [2:0] REG_ACTIVE_COUNT  = 3'd0;
    localparam logic [2:0] REG_BOX_WIDTH     = 3'd1;
    localparam logic [2:0] REG_CONTACT       = 3'd2;
    localparam logic [2:0] REG_COUPLING      = 3'd3;
    localparam logic [2:0] REG_FIELD_ENABLE  = 3'd4;
    localparam logic [2:0] REG_FIELD_CENTER  = 3'd5;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic signed [47:0] EXP_LIMIT = 48'sd786432;

    typedef enum logic [1:0] {
        TU_IDLE,
        TU_SQRT,
        TU_DIV
    } term_state_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BAD,
        ST_LOAD,
        ST_OWN_RD,
        ST_OWN,
        ST_C2,
        ST_PAIR_NEXT,
        ST_PAIR_RD,
        ST_SQ,
        ST_SQ_ACC,
        ST_PAIR_CHK,
        ST_TERM_WAIT,
        ST_EXT_SETUP,
        ST_EXT_NEXT,
        ST_EXP1,
        ST_EXP2,
        ST_EXP3,
        ST_FIN
    } top_state_t;

    typedef struct packed {
        logic        start;
        logic        plain;
        logic [33:0] value;
    } term_req_t;

    typedef struct packed {
        logic        done;
        logic [30:0] quotient;
    } term_rsp_t;

    function automatic logic [16:0] exp2_tab(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:  v = 17'd65536;
            5'd1:  v = 17'd62757;
            5'd2:  v = 17'd60097;
            5'd3:  v = 17'd57549;
            5'd4:  v = 17'd55109;
            5'd5:  v = 17'd52773;
            5'd6:  v = 17'd50535;
            5'd7:  v = 17'd48393;
            5'd8:  v = 17'd46341;
            5'd9:  v = 17'd44376;
            5'd10: v = 17'd42495;
            5'd11: v = 17'd40693;
            5'd12: v = 17'd38968;
            5'd13: v = 17'd37316;
            5'd14: v = 17'd35734;
            5'd15: v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/mims_store.sv
// ---------------------------------------------------------------------------
// Ion store
// One write port and one registered read port holding position and charge.
// ---------------------------------------------------------------------------
`default_nettype none
module mims_store
    import mims_pkg::*;
#(
    parameter int DEPTH = 512,
    parameter int AW = 9
)
(
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [AW-1:0]      waddr,
    input  wire logic [STORE_W-1:0] wdata,
    input  wire logic [AW-1:0]      raddr,
    output logic      [STORE_W-1:0] rdata
);

    logic [STORE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/mims_term.sv
// ---------------------------------------------------------------------------
// Coulomb term unit
// Bit-serial square root followed by a restoring divide of lB by distance; plain requests skip the square root.
// ---------------------------------------------------------------------------
`default_nettype none
module mims_term
    import mims_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic [15:0] lb,
    input  wire term_req_t req,
    output term_rsp_t      rsp
);

    term_state_t state_reg, state_next;
    logic [33:0] rad_reg, rad_next;
    logic [18:0] rem_sq_reg, rem_sq_next;
    logic [16:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [16:0] div_reg, div_next;
    logic [16:0] rem_dv_reg, rem_dv_next;
    logic [30:0] quo_reg, quo_next;
    logic        done_reg, done_next;

    logic [20:0] sq_sh;
    logic [20:0] sq_trial;
    logic [17:0] dv_sh;
    logic        dv_bit;

    always_comb
    begin
        state_next  = state_reg;
        rad_next    = rad_reg;
        rem_sq_next = rem_sq_reg;
        root_next   = root_reg;
        cnt_next    = cnt_reg;
        div_next    = div_reg;
        rem_dv_next = rem_dv_reg;
        quo_next    = quo_reg;
        done_next   = 1'b0;
        sq_sh       = {rem_sq_reg, rad_reg[33:32]};
        sq_trial    = {2'b00, root_reg, 2'b01};
        dv_sh       = {rem_dv_reg, quo_reg[30]};
        dv_bit      = (dv_sh >= {1'b0, div_reg});
        case (state_reg)
            TU_IDLE:
            begin
                if (req.start)
                begin
                    cnt_next = 5'd0;
                    if (req.plain)
                    begin
                        div_next    = (req.value[16:0] == 17'd0) ? 17'd1 : req.value[16:0];
                        quo_next    = {lb, 15'd0};
                        rem_dv_next = 17'd0;
                        state_next  = TU_DIV;
                    end
                    else
                    begin
                        rad_next    = req.value;
                        rem_sq_next = 19'd0;
                        root_next   = 17'd0;
                        state_next  = TU_SQRT;
                    end
                end
            end
            TU_SQRT:
            begin
                if (sq_sh >= sq_trial)
                begin
                    rem_sq_next = 19'(sq_sh - sq_trial);
                    root_next   = {root_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_sq_next = sq_sh[18:0];
                    root_next   = {root_reg[15:0], 1'b0};
                end
                rad_next = {rad_reg[31:0], 2'b00};
                if (cnt_reg == 5'd16)
                begin
                    div_next    = (root_next == 17'd0) ? 17'd1 : root_next;
                    quo_next    = {lb, 15'd0};
                    rem_dv_next = 17'd0;
                    cnt_next    = 5'd0;
                    state_next  = TU_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            TU_DIV:
            begin
                if (dv_bit)
                begin
                    rem_dv_next = 17'(dv_sh - {1'b0, div_reg});
                end
                else
                begin
                    rem_dv_next = dv_sh[16:0];
                end
                quo_next = {quo_reg[29:0], dv_bit};
                if (cnt_reg == 5'd30)
                begin
                    done_next  = 1'b1;
                    state_next = TU_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            default:
            begin
                state_next = TU_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TU_IDLE;
            cnt_reg   <= 5'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg    <= rad_next;
        rem_sq_reg <= rem_sq_next;
        root_reg   <= root_next;
        div_reg    <= div_next;
        rem_dv_reg <= rem_dv_next;
        quo_reg    <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

FILE: rtl/metropolis_ion_move_step.sv
// ---------------------------------------------------------------------------
// Metropolis ion move step
// Loads ions into a store and evaluates Metropolis moves with Coulomb energy.
// ---------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. A load writes
// one ion in the load state, which also sets the result registers. A move
// reads the ion, then walks the store one ion at a time: the own ion is
// passed over, a close ion is skipped, and a counted pair goes through the
// shared term unit (17 square root steps and 31 divide steps per distance,
// two distances per pair). The external terms first square the offsets, then
// take a square root and a divide for each point or line distance and a
// divide only for each plane distance, and the acceptance decision comes last.
// The result word is shown for one cycle with result_valid high; the
// receiver cannot stall it. Busy stays high until the result is shown, and
// a new command may be given in the cycle the result is shown.
// Reset returns the state, result_valid and configuration registers to their
// defaults; the store is undefined until loaded. Configuration writes are
// taken at any edge with cfg_we high.
// ---------------------------------------------------------------------------
`default_nettype none
`include "metropolis_ion_move_step_macros.svh"
module metropolis_ion_move_step
    import mims_pkg::*;
#(
    parameter int MAX_IONS = 512
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               command,
    input  wire logic [8:0]         ion_index,
    input  wire logic [15:0]        load_x,
    input  wire logic [15:0]        load_y,
    input  wire logic [15:0]        load_z,
    input  wire logic               positive_charge,
    input  wire logic signed [11:0] move_x,
    input  wire logic signed [11:0] move_y,
    input  wire logic signed [11:0] move_z,
    input  wire logic [15:0]        accept_random,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    output logic                    result_valid,
    output logic [1:0]              status,
    output logic signed [15:0]      energy_change,
    output logic [15:0]             final_x,
    output logic [15:0]             final_y,
    output logic [15:0]             final_z
);

    localparam int AW = (MAX_IONS > 1) ? $clog2(MAX_IONS) : 1;
    localparam int CW = $clog2(MAX_IONS + 1);

    function automatic logic [15:0] wrap_pos(input logic [15:0] old,
                                             input logic signed [11:0] mv,
                                             input logic [15:0] bw);
        logic signed [17:0] p;
        p = $signed({2'b00, old}) + 18'(mv);
        if (p < 18'sd0)
        begin
            p = p + $signed({2'b00, bw});
        end
        else if (p >= $signed({2'b00, bw}))
        begin
            p = p - $signed({2'b00, bw});
        end
        return p[15:0];
    endfunction

    function automatic logic [15:0] min_image(input logic [15:0] a, input logic [15:0] b,
                                              input logic [15:0] bw);
        logic signed [17:0] d;
        logic signed [17:0] half;
        d    = $signed({2'b00, a}) - $signed({2'b00, b});
        half = $signed({3'b000, bw[15:1]});
        if (d > half)
        begin
            d = d - $signed({2'b00, bw});
        end
        else if (d < -half)
        begin
            d = d + $signed({2'b00, bw});
        end
        if (d < 18'sd0)
        begin
            d = -d;
        end
        return d[15:0];
    endfunction

    function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // Configuration registers
    logic [9:0]  active_count_reg;
    logic [15:0] box_width_reg;
    logic [15:0] contact_reg;
    logic [15:0] coupling_reg;
    logic [2:0]  field_enable_reg;
    logic [15:0] field_center_reg;

    top_state_t state_reg, state_next;
    logic            cmd_reg, cmd_next;
    logic [8:0]      idx_reg, idx_next;
    logic [15:0]     lx_reg, lx_next, ly_reg, ly_next, lz_reg, lz_next;
    logic            lpos_reg, lpos_next;
    logic signed [11:0] mvx_reg, mvx_next, mvy_reg, mvy_next, mvz_reg, mvz_next;
    logic [15:0]     rnd_reg, rnd_next;
    logic [15:0]     ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic [15:0]     nx_reg, nx_next, ny_reg, ny_next, nz_reg, nz_next;
    logic            own_pos_reg, own_pos_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [31:0]     c2_reg, c2_next;
    logic [15:0]     m_reg [6];
    logic [15:0]     m_next [6];
    logic [2:0]      sq_cnt_reg, sq_cnt_next;
    logic [33:0]     sum_new_reg, sum_new_next, sum_old_reg, sum_old_next;
    logic [33:0]     xy_new_reg, xy_new_next, xy_old_reg, xy_old_next;
    logic            pair_mode_reg, pair_mode_next;
    logic            pair_same_reg, pair_same_next;
    logic            tsel_reg, tsel_next;
    logic [2:0]      ext_cnt_reg, ext_cnt_next;
    logic signed [47:0] d_reg, d_next;
    logic [3:0]      kexp_reg, kexp_next;
    logic [3:0]      tidx_reg, tidx_next;
    logic            acc_reg, acc_next;
    logic            result_valid_reg, result_valid_next;
    logic [1:0]      status_reg, status_next;
    logic signed [15:0] energy_reg, energy_next;
    logic [15:0]     fx_reg, fx_next, fy_reg, fy_next, fz_reg, fz_next;

    logic [19:0]     mul_a;
    logic [16:0]     mul_b;
    logic [36:0]     prod_reg;

    logic                mem_we;
    logic [AW-1:0]       mem_raddr;
    logic [STORE_W-1:0]  mem_wdata;
    logic [STORE_W-1:0]  mem_rdata;
    logic [AW-1:0]       idx_addr;

    term_req_t term_req;
    term_rsp_t term_rsp;

    logic signed [47:0] term_ext;
    logic               term_neg;
    logic signed [47:0] e_full;
    logic [20:0]        y_val;
    logic [16:0]        tab_a;
    logic [16:0]        tab_b;
    logic [16:0]        v_val;
    logic               ext_en;

    assign idx_addr = AW'(idx_reg);

    mims_store #(.DEPTH(MAX_IONS), .AW(AW)) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (idx_addr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mims_term u_term (
        .clk   (clk),
        .rst_n (rst_n),
        .lb    (coupling_reg),
        .req   (term_req),
        .rsp   (term_rsp)
    );

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        idx_next          = idx_reg;
        lx_next           = lx_reg;
        ly_next           = ly_reg;
        lz_next           = lz_reg;
        lpos_next         = lpos_reg;
        mvx_next          = mvx_reg;
        mvy_next          = mvy_reg;
        mvz_next          = mvz_reg;
        rnd_next          = rnd_reg;
        ox_next           = ox_reg;
        oy_next           = oy_reg;
        oz_next           = oz_reg;
        nx_next           = nx_reg;
        ny_next           = ny_reg;
        nz_next           = nz_reg;
        own_pos_next      = own_pos_reg;
        n_next            = n_reg;
        j_next            = j_reg;
        c2_next           = c2_reg;
        m_next            = m_reg;
        sq_cnt_next       = sq_cnt_reg;
        sum_new_next      = sum_new_reg;
        sum_old_next      = sum_old_reg;
        xy_new_next       = xy_new_reg;
        xy_old_next       = xy_old_reg;
        pair_mode_next    = pair_mode_reg;
        pair_same_next    = pair_same_reg;
        tsel_next         = tsel_reg;
        ext_cnt_next      = ext_cnt_reg;
        d_next            = d_reg;
        kexp_next         = kexp_reg;
        tidx_next         = tidx_reg;
        acc_next          = acc_reg;
        result_valid_next = 1'b0;
        status_next       = status_reg;
        energy_next       = energy_reg;
        fx_next           = fx_reg;
        fy_next           = fy_reg;
        fz_next           = fz_reg;
        mem_we            = 1'b0;
        mem_wdata         = {own_pos_reg, nz_reg, ny_reg, nx_reg};
        mem_raddr         = idx_addr;
        mul_a             = 20'd0;
        mul_b             = 17'd0;
        term_req          = '0;
        term_ext          = $signed({17'd0, term_rsp.quotient});
        term_neg          = tsel_reg ^ !(pair_mode_reg ? pair_same_reg : own_pos_reg);
        e_full            = d_reg >>> 8;
        y_val             = prod_reg[36:16];
        tab_a             = exp2_tab({1'b0, tidx_reg});
        tab_b             = exp2_tab(5'({1'b0, tidx_reg}) + 5'd1);
        v_val             = (tab_a - {5'd0, prod_reg[23:12]}) >> kexp_reg;
        ext_en            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = command;
                    idx_next  = ion_index;
                    lx_next   = load_x;
                    ly_next   = load_y;
                    lz_next   = load_z;
                    lpos_next = positive_charge;
                    mvx_next  = move_x;
                    mvy_next  = move_y;
                    mvz_next  = move_z;
                    rnd_next  = accept_random;
                    if (32'(ion_index) >= MAX_IONS)
                    begin
                        state_next = ST_BAD;
                    end
                    else if (command == CMD_LOAD)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_OWN_RD;
                    end
                end
            end
            ST_BAD:
            begin
                status_next       = (cmd_reg == CMD_MOVE) ? STATUS_REJECTED : STATUS_LOADED;
                energy_next       = 16'sd0;
                fx_next           = 16'd0;
                fy_next           = 16'd0;
                fz_next           = 16'd0;
                result_valid_next = 1'b1;
                state_next        = ST_IDLE;
            end
            ST_LOAD:
            begin
                mem_we            = 1'b1;
                mem_wdata         = {lpos_reg, lz_reg, ly_reg, lx_reg};
                status_next       = STATUS_LOADED;
                energy_next       = 16'sd0;
                fx_next           = lx_reg;
                fy_next           = ly_reg;
                fz_next           = lz_reg;
                result_valid_next = 1'b1;
                state_next        = ST_IDLE;
            end
            ST_OWN_RD:
            begin
                state_next = ST_OWN;
            end
            ST_OWN:
            begin
                ox_next      = mem_rdata[15:0];
                oy_next      = mem_rdata[31:16];
                oz_next      = mem_rdata[47:32];
                own_pos_next = mem_rdata[48];
                nx_next      = wrap_pos(mem_rdata[15:0], mvx_reg, box_width_reg);
                ny_next      = wrap_pos(mem_rdata[31:16], mvy_reg, box_width_reg);
                nz_next      = wrap_pos(mem_rdata[47:32], mvz_reg, box_width_reg);
                mul_a        = {4'd0, contact_reg};
                mul_b        = {1'b0, contact_reg};
                if (32'(active_count_reg) > MAX_IONS)
                begin
                    n_next = CW'(MAX_IONS);
                end
                else
                begin
                    n_next = CW'(active_count_reg);
                end
                j_next     = '0;
                d_next     = 48'sd0;
                state_next = ST_C2;
            end
            ST_C2:
            begin
                c2_next    = prod_reg[31:0];
                state_next = ST_PAIR_NEXT;
            end
            ST_PAIR_NEXT:
            begin
                if (j_reg >= n_reg)
                begin
                    state_next = ST_EXT_SETUP;
                end
                else if (32'(j_reg) == 32'(idx_reg))
                begin
                    j_next = j_reg + CW'(1);
                end
                else
                begin
                    mem_raddr  = j_reg[AW-1:0];
                    state_next = ST_PAIR_RD;
                end
            end
            ST_PAIR_RD:
            begin
                m_next[0]      = min_image(nx_reg, mem_rdata[15:0], box_width_reg);
                m_next[1]      = min_image(ny_reg, mem_rdata[31:16], box_width_reg);
                m_next[2]      = min_image(nz_reg, mem_rdata[47:32], box_width_reg);
                m_next[3]      = min_image(ox_reg, mem_rdata[15:0], box_width_reg);
                m_next[4]      = min_image(oy_reg, mem_rdata[31:16], box_width_reg);
                m_next[5]      = min_image(oz_reg, mem_rdata[47:32], box_width_reg);
                pair_same_next = (mem_rdata[48] == own_pos_reg);
                pair_mode_next = 1'b1;
                sum_new_next   = 34'd0;
                sum_old_next   = 34'd0;
                xy_new_next    = 34'd0;
                xy_old_next    = 34'd0;
                sq_cnt_next    = 3'd0;
                state_next     = ST_SQ;
            end
            ST_SQ:
            begin
                mul_a      = {4'd0, m_reg[sq_cnt_reg]};
                mul_b      = {1'b0, m_reg[sq_cnt_reg]};
                state_next = ST_SQ_ACC;
            end
            ST_SQ_ACC:
            begin
                if (sq_cnt_reg < 3'd3)
                begin
                    sum_new_next = sum_new_reg + {2'd0, prod_reg[31:0]};
                    if (sq_cnt_reg < 3'd2)
                    begin
                        xy_new_next = xy_new_reg + {2'd0, prod_reg[31:0]};
                    end
                end
                else
                begin
                    sum_old_next = sum_old_reg + {2'd0, prod_reg[31:0]};
                    if (sq_cnt_reg < 3'd5)
                    begin
                        xy_old_next = xy_old_reg + {2'd0, prod_reg[31:0]};
                    end
                end
                if (sq_cnt_reg == 3'd5)
                begin
                    if (pair_mode_reg)
                    begin
                        state_next = ST_PAIR_CHK;
                    end
                    else
                    begin
                        ext_cnt_next = 3'd0;
                        state_next   = ST_EXT_NEXT;
                    end
                end
                else
                begin
                    sq_cnt_next = sq_cnt_reg + 3'd1;
                    state_next  = ST_SQ;
                end
            end
            ST_PAIR_CHK:
            begin
                if (sum_new_reg < {2'd0, c2_reg})
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = ST_PAIR_NEXT;
                end
                else
                begin
                    term_req.start = 1'b1;
                    term_req.value = sum_new_reg;
                    tsel_next      = 1'b0;
                    state_next     = ST_TERM_WAIT;
                end
            end
            ST_TERM_WAIT:
            begin
                if (term_rsp.done)
                begin
                    d_next = term_neg ? (d_reg - term_ext) : (d_reg + term_ext);
                    if (pair_mode_reg)
                    begin
                        if (!tsel_reg)
                        begin
                            term_req.start = 1'b1;
                            term_req.value = sum_old_reg;
                            tsel_next      = 1'b1;
                        end
                        else
                        begin
                            j_next     = j_reg + CW'(1);
                            state_next = ST_PAIR_NEXT;
                        end
                    end
                    else
                    begin
                        ext_cnt_next = ext_cnt_reg + 3'd1;
                        state_next   = ST_EXT_NEXT;
                    end
                end
            end
            ST_EXT_SETUP:
            begin
                m_next[0]      = abs_diff(nx_reg, field_center_reg);
                m_next[1]      = abs_diff(ny_reg, field_center_reg);
                m_next[2]      = abs_diff(nz_reg, field_center_reg);
                m_next[3]      = abs_diff(ox_reg, field_center_reg);
                m_next[4]      = abs_diff(oy_reg, field_center_reg);
                m_next[5]      = abs_diff(oz_reg, field_center_reg);
                pair_mode_next = 1'b0;
                sum_new_next   = 34'd0;
                sum_old_next   = 34'd0;
                xy_new_next    = 34'd0;
                xy_old_next    = 34'd0;
                sq_cnt_next    = 3'd0;
                state_next     = ST_SQ;
            end
            ST_EXT_NEXT:
            begin
                case (ext_cnt_reg)
                    3'd0:
                    begin
                        ext_en         = field_enable_reg[0];
                        term_req.value = sum_new_reg;
                    end
                    3'd1:
                    begin
                        ext_en         = field_enable_reg[1];
                        term_req.value = xy_new_reg;
                    end
                    3'd2:
                    begin
                        ext_en         = field_enable_reg[2];
                        term_req.plain = 1'b1;
                        term_req.value = {18'd0, m_reg[2]};
                    end
                    3'd3:
                    begin
                        ext_en         = field_enable_reg[0];
                        term_req.value = sum_old_reg;
                    end
                    3'd4:
                    begin
                        ext_en         = field_enable_reg[1];
                        term_req.value = xy_old_reg;
                    end
                    3'd5:
                    begin
                        ext_en         = field_enable_reg[2];
                        term_req.plain = 1'b1;
                        term_req.value = {18'd0, m_reg[5]};
                    end
                    default:
                    begin
                        ext_en = 1'b0;
                    end
                endcase
                if (ext_cnt_reg == 3'd6)
                begin
                    state_next = ST_EXP1;
                end
                else if (ext_en)
                begin
                    term_req.start = 1'b1;
                    tsel_next      = (ext_cnt_reg >= 3'd3);
                    state_next     = ST_TERM_WAIT;
                end
                else
                begin
                    ext_cnt_next = ext_cnt_reg + 3'd1;
                end
            end
            ST_EXP1:
            begin
                if (e_full > 48'sd32767)
                begin
                    energy_next = 16'sd32767;
                end
                else if (e_full < -48'sd32768)
                begin
                    energy_next = -16'sd32768;
                end
                else
                begin
                    energy_next = e_full[15:0];
                end
                if (d_reg <= 48'sd0)
                begin
                    acc_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else if (d_reg >= EXP_LIMIT)
                begin
                    acc_next   = 1'b0;
                    state_next = ST_FIN;
                end
                else
                begin
                    mul_a      = d_reg[19:0];
                    mul_b      = LOG2E_Q16;
                    state_next = ST_EXP2;
                end
            end
            ST_EXP2:
            begin
                if (y_val[20:16] >= 5'd16)
                begin
                    acc_next   = 1'b0;
                    state_next = ST_FIN;
                end
                else
                begin
                    kexp_next  = y_val[19:16];
                    tidx_next  = y_val[15:12];
                    mul_a      = 20'(exp2_tab({1'b0, y_val[15:12]})
                                     - exp2_tab(5'({1'b0, y_val[15:12]}) + 5'd1));
                    mul_b      = {5'd0, y_val[11:0]};
                    state_next = ST_EXP3;
                end
            end
            ST_EXP3:
            begin
                acc_next   = (v_val > {1'b0, rnd_reg}) && (tab_b <= tab_a);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                mem_we            = acc_reg;
                status_next       = acc_reg ? STATUS_ACCEPTED : STATUS_REJECTED;
                fx_next           = acc_reg ? nx_reg : ox_reg;
                fy_next           = acc_reg ? ny_reg : oy_reg;
                fz_next           = acc_reg ? nz_reg : oz_reg;
                result_valid_next = 1'b1;
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            active_count_reg <= 10'd200;
            box_width_reg    <= 16'd40960;
            contact_reg      <= 16'd2048;
            coupling_reg     <= 16'd2924;
            field_enable_reg <= 3'd7;
            field_center_reg <= 16'd20480;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ACTIVE_COUNT: active_count_reg <= cfg_data[9:0];
                    REG_BOX_WIDTH:    box_width_reg    <= cfg_data;
                    REG_CONTACT:      contact_reg      <= cfg_data;
                    REG_COUPLING:     coupling_reg     <= cfg_data;
                    REG_FIELD_ENABLE: field_enable_reg <= cfg_data[2:0];
                    REG_FIELD_CENTER: field_center_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        lx_reg        <= lx_next;
        ly_reg        <= ly_next;
        lz_reg        <= lz_next;
        lpos_reg      <= lpos_next;
        mvx_reg       <= mvx_next;
        mvy_reg       <= mvy_next;
        mvz_reg       <= mvz_next;
        rnd_reg       <= rnd_next;
        ox_reg        <= ox_next;
        oy_reg        <= oy_next;
        oz_reg        <= oz_next;
        nx_reg        <= nx_next;
        ny_reg        <= ny_next;
        nz_reg        <= nz_next;
        own_pos_reg   <= own_pos_next;
        n_reg         <= n_next;
        j_reg         <= j_next;
        c2_reg        <= c2_next;
        m_reg         <= m_next;
        sq_cnt_reg    <= sq_cnt_next;
        sum_new_reg   <= sum_new_next;
        sum_old_reg   <= sum_old_next;
        xy_new_reg    <= xy_new_next;
        xy_old_reg    <= xy_old_next;
        pair_mode_reg <= pair_mode_next;
        pair_same_reg <= pair_same_next;
        tsel_reg      <= tsel_next;
        ext_cnt_reg   <= ext_cnt_next;
        d_reg         <= d_next;
        kexp_reg      <= kexp_next;
        tidx_reg      <= tidx_next;
        acc_reg       <= acc_next;
        status_reg    <= status_next;
        energy_reg    <= energy_next;
        fx_reg        <= fx_next;
        fy_reg        <= fy_next;
        fz_reg        <= fz_next;
        prod_reg      <= mul_a * mul_b;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result_valid  = result_valid_reg;
    assign status        = status_reg;
    assign energy_change = energy_reg;
    assign final_x       = fx_reg;
    assign final_y       = fy_reg;
    assign final_z       = fz_reg;

    `MIMS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `MIMS_ASSERT_NXT(a_strobe_single, result_valid, !result_valid, "result shown twice")
    `MIMS_ASSERT_IMP(a_load_zero, result_valid && status == STATUS_LOADED, energy_change == 16'sd0, "load result carries energy")
    `MIMS_ASSERT_IMP(a_term_idle, term_rsp.done, state_reg == ST_TERM_WAIT, "term result with no requester")

endmodule
`default_nettype wire
